>>> hw/rtl/swhsv_pkg.sv
// ----------------------------------------------------------------------------
// swhsv_pkg
// Shared constants, register indexes and the quarter-wave sine table for the
// sine-wave HSV pattern generator.
// ----------------------------------------------------------------------------
package swhsv_pkg;

  // default geometry and frame rate
  localparam int MATRIX_WIDTH      = 32;
  localparam int MATRIX_HEIGHT     = 32;
  localparam int FRAMES_PER_SECOND = 30;

  // frame counter and phase magnitude widths
  localparam int FRAME_W = 20;
  localparam int MAG_W   = FRAME_W + 1;

  // configuration register indexes
  localparam logic [2:0] REG_WAVE_MODE    = 3'd0;
  localparam logic [2:0] REG_REVERSE      = 3'd1;
  localparam logic [2:0] REG_WAVE_LENGTH  = 3'd2;
  localparam logic [2:0] REG_SPEED        = 3'd3;
  localparam logic [2:0] REG_HUE_BOUNDS   = 3'd4;
  localparam logic [2:0] REG_SAT_BOUNDS   = 3'd5;
  localparam logic [2:0] REG_VALUE_BOUNDS = 3'd6;

  // input item kinds
  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // register reset values
  localparam logic [7:0]  RST_WAVE_LENGTH  = 8'd25;
  localparam logic [7:0]  RST_SPEED        = 8'd50;
  localparam logic [15:0] RST_HUE_BOUNDS   = 16'hFF00;
  localparam logic [15:0] RST_SAT_BOUNDS   = 16'h00FF;
  localparam logic [15:0] RST_VALUE_BOUNDS = 16'h964B;

  // x/10 as (x * DIV10_MUL) >> DIV10_SHIFT, exact for 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // round(128*sin(pi*j/128)) for j = 0..64
  function automatic logic [7:0] quarter_sine(input logic [6:0] j);
    logic [7:0] v;
    case (j)
      7'd0:  v = 8'd0;   7'd1:  v = 8'd3;   7'd2:  v = 8'd6;   7'd3:  v = 8'd9;
      7'd4:  v = 8'd13;  7'd5:  v = 8'd16;  7'd6:  v = 8'd19;  7'd7:  v = 8'd22;
      7'd8:  v = 8'd25;  7'd9:  v = 8'd28;  7'd10: v = 8'd31;  7'd11: v = 8'd34;
      7'd12: v = 8'd37;  7'd13: v = 8'd40;  7'd14: v = 8'd43;  7'd15: v = 8'd46;
      7'd16: v = 8'd49;  7'd17: v = 8'd52;  7'd18: v = 8'd55;  7'd19: v = 8'd58;
      7'd20: v = 8'd60;  7'd21: v = 8'd63;  7'd22: v = 8'd66;  7'd23: v = 8'd68;
      7'd24: v = 8'd71;  7'd25: v = 8'd74;  7'd26: v = 8'd76;  7'd27: v = 8'd79;
      7'd28: v = 8'd81;  7'd29: v = 8'd84;  7'd30: v = 8'd86;  7'd31: v = 8'd88;
      7'd32: v = 8'd91;  7'd33: v = 8'd93;  7'd34: v = 8'd95;  7'd35: v = 8'd97;
      7'd36: v = 8'd99;  7'd37: v = 8'd101; 7'd38: v = 8'd103; 7'd39: v = 8'd105;
      7'd40: v = 8'd106; 7'd41: v = 8'd108; 7'd42: v = 8'd110; 7'd43: v = 8'd111;
      7'd44: v = 8'd113; 7'd45: v = 8'd114; 7'd46: v = 8'd116; 7'd47: v = 8'd117;
      7'd48: v = 8'd118; 7'd49: v = 8'd119; 7'd50: v = 8'd121; 7'd51: v = 8'd122;
      7'd52: v = 8'd122; 7'd53: v = 8'd123; 7'd54: v = 8'd124; 7'd55: v = 8'd125;
      7'd56: v = 8'd126; 7'd57: v = 8'd126; 7'd58: v = 8'd127; 7'd59: v = 8'd127;
      7'd60: v = 8'd127; 7'd61: v = 8'd128; 7'd62: v = 8'd128; 7'd63: v = 8'd128;
      7'd64: v = 8'd128;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/sine_wave_hsv_pattern.sv
// ----------------------------------------------------------------------------
// sine_wave_hsv_pattern
// Travelling sine-wave HSV pattern: answers pixel colour queries and advances
// the wave phase on frame ticks.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready   | tuser: func; tdata: col, row
//  m_axis  | out | m_axis_tvalid/tready   | tdata: hue, saturation, brightness
//  cfg     | in  | cfg_valid/cfg_ready    | cfg_index: register, cfg_data: value
//
//  a query runs through accept, load, 21 remainder steps, sign fix, 8 fraction steps,
//  sine lookup, 3 blend steps and output push; a tick through accept, multiply,
//  divide and add. remainder and fraction steps share the single compare-subtract
//  unit, which forms the phase remainder and its 8-bit fraction one bit per cycle.
//  reset clears the frame counter and loads the register defaults.
//  a result waits in the output register; the sequencer stalls in its push
//  cycle only while a previous result has not yet been transferred.
// ----------------------------------------------------------------------------
module sine_wave_hsv_pattern
  import swhsv_pkg::*;
#(
  parameter int MatrixWidth     = MATRIX_WIDTH,
  parameter int MatrixHeight    = MATRIX_HEIGHT,
  parameter int FramesPerSecond = FRAMES_PER_SECOND
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [5:0] col, [11:6] row, [15:12] zero
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] hue, [15:8] saturation, [23:16] brightness
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int U    = FramesPerSecond * 10;
  localparam int DW   = $clog2(U * 255 + 1);
  localparam int VW   = MAG_W + 1;
  localparam int CW   = ($clog2(MAG_W) > 3) ? $clog2(MAG_W) : 3;
  localparam logic signed [7:0]  XMax  = 8'(MatrixWidth - 1);
  localparam logic signed [7:0]  YMax  = 8'(MatrixHeight - 1);
  localparam logic signed [VW-1:0] UExt = VW'(U);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LOAD     = 4'd1;
  localparam logic [3:0] ST_MOD      = 4'd2;
  localparam logic [3:0] ST_FIX      = 4'd3;
  localparam logic [3:0] ST_FRAC     = 4'd4;
  localparam logic [3:0] ST_SINE     = 4'd5;
  localparam logic [3:0] ST_BLEND    = 4'd6;
  localparam logic [3:0] ST_PUSH     = 4'd7;
  localparam logic [3:0] ST_TICK_MUL = 4'd8;
  localparam logic [3:0] ST_TICK_DIV = 4'd9;
  localparam logic [3:0] ST_TICK_ADD = 4'd10;

  // configuration registers
  logic        mode_q, rev_q;
  logic [7:0]  wl_q, speed_q;
  logic [15:0] hue_bnd_q, sat_bnd_q, val_bnd_q;

  // sequencer and datapath state
  logic [3:0]         state_q, state_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [1:0]         ch_q, ch_d;
  logic               neg_q, neg_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic [DW-1:0]      rem_q, rem_d;
  logic [DW-1:0]      d_q, d_d;
  logic [7:0]         idx_q, idx_d;
  logic [8:0]         f_q, f_d;
  logic [5:0]         col_q, row_q;
  logic [15:0]        prod_q, prod_d;
  logic [12:0]        step_q, step_d;
  logic [7:0]         res_q [3];
  logic [23:0]        out_data_q;
  logic               out_valid_q, out_valid_d;

  logic in_xfer;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      rev_q     <= 1'b1;
      wl_q      <= RST_WAVE_LENGTH;
      speed_q   <= RST_SPEED;
      hue_bnd_q <= RST_HUE_BOUNDS;
      sat_bnd_q <= RST_SAT_BOUNDS;
      val_bnd_q <= RST_VALUE_BOUNDS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WAVE_MODE:    mode_q    <= cfg_data_i[0];
        REG_REVERSE:      rev_q     <= cfg_data_i[0];
        REG_WAVE_LENGTH:  wl_q      <= (cfg_data_i[7:0] == 8'd0) ? 8'd1 : cfg_data_i[7:0];
        REG_SPEED:        speed_q   <= cfg_data_i[7:0];
        REG_HUE_BOUNDS:   hue_bnd_q <= cfg_data_i;
        REG_SAT_BOUNDS:   sat_bnd_q <= cfg_data_i;
        REG_VALUE_BOUNDS: val_bnd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // signed wave position and phase offset pos*U - frame
  logic signed [7:0]    pos_s;
  logic signed [VW-1:0] pos_ext, v_s;
  always_comb begin
    if (!mode_q) begin
      pos_s = rev_q ? (XMax - signed'({2'b00, col_q})) : signed'({2'b00, col_q});
    end else begin
      pos_s = rev_q ? (YMax - signed'({2'b00, row_q})) : signed'({2'b00, row_q});
    end
    pos_ext = VW'(pos_s);
    v_s     = pos_ext * UExt - signed'({2'b00, frame_q});
  end

  // shared compare-subtract unit: shift one bit into the remainder
  logic          shift_bit;
  logic [DW:0]   trial, diff;
  logic          ge;
  always_comb begin
    shift_bit = (state_q == ST_MOD) ? mag_q[MAG_W-1] : 1'b0;
    trial     = {rem_q, shift_bit};
    diff      = trial - {1'b0, d_q};
    ge        = (trial >= {1'b0, d_q});
  end

  // sine lookup
  logic [6:0] sine_j;
  logic [7:0] sine_mag;
  always_comb begin
    sine_j   = idx_q[6] ? (7'd64 - {1'b0, idx_q[5:0]}) : {1'b0, idx_q[5:0]};
    sine_mag = quarter_sine(sine_j);
  end

  // one channel blend per cycle
  logic [15:0] bnd;
  logic [7:0]  lo, hi, span, blend_res;
  logic [8:0]  fx;
  logic [16:0] blend_prod;
  always_comb begin
    case (ch_q)
      2'd0:    bnd = hue_bnd_q;
      2'd1:    bnd = sat_bnd_q;
      2'd2:    bnd = val_bnd_q;
      default: bnd = val_bnd_q;
    endcase
    if (bnd[7:0] > bnd[15:8]) begin
      lo = bnd[15:8];
      hi = bnd[7:0];
      fx = 9'd256 - f_q;
    end else begin
      lo = bnd[7:0];
      hi = bnd[15:8];
      fx = f_q;
    end
    span       = hi - lo;
    blend_prod = 17'(span) * 17'(fx);
    blend_res  = lo + blend_prod[15:8];
  end

  // tick arithmetic
  logic [31:0]      recip;
  logic [FRAME_W:0] frame_sum;
  always_comb begin
    recip     = 32'(prod_q) * 32'(DIV10_MUL);
    frame_sum = {1'b0, frame_q} + (FRAME_W + 1)'(step_q);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    cnt_d       = cnt_q;
    ch_d        = ch_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    d_d         = d_q;
    idx_d       = idx_q;
    f_d         = f_q;
    prod_d      = prod_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (s_axis_tuser_i == FUNC_TICK) ? ST_TICK_MUL : ST_LOAD;
        end
      end
      ST_LOAD: begin
        neg_d   = v_s[VW-1];
        mag_d   = v_s[VW-1] ? MAG_W'(-v_s) : MAG_W'(v_s);
        d_d     = DW'(wl_q * U);
        rem_d   = '0;
        cnt_d   = CW'(MAG_W - 1);
        state_d = ST_MOD;
      end
      ST_MOD: begin
        rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
        mag_d = {mag_q[MAG_W-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        // negative offsets fold back into 0..D-1
        if (neg_q && (rem_q != '0)) begin
          rem_d = d_q - rem_q;
        end
        cnt_d   = CW'(7);
        state_d = ST_FRAC;
      end
      ST_FRAC: begin
        rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
        idx_d = {idx_q[6:0], ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_SINE;
        end
      end
      ST_SINE: begin
        f_d     = idx_q[7] ? (9'd128 - {1'b0, sine_mag}) : (9'd128 + {1'b0, sine_mag});
        ch_d    = 2'd0;
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        ch_d = ch_q + 2'd1;
        if (ch_q == 2'd2) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_TICK_MUL: begin
        prod_d  = 16'(wl_q) * 16'(speed_q);
        d_d     = DW'(wl_q * U);
        state_d = ST_TICK_DIV;
      end
      ST_TICK_DIV: begin
        step_d  = recip[DIV10_SHIFT +: 13];
        state_d = ST_TICK_ADD;
      end
      ST_TICK_ADD: begin
        // wrap to one once the frame reaches the full period
        frame_d = (frame_sum >= (FRAME_W + 1)'(d_q)) ? FRAME_W'(1) : frame_sum[FRAME_W-1:0];
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    ch_q   <= ch_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    d_q    <= d_d;
    idx_q  <= idx_d;
    f_q    <= f_d;
    prod_q <= prod_d;
    step_q <= step_d;
    if (in_xfer) begin
      col_q <= s_axis_tdata_i[5:0];
      row_q <= s_axis_tdata_i[11:6];
    end
    if (state_q == ST_BLEND) begin
      res_q[ch_q] <= blend_res;
    end
    if ((state_q == ST_PUSH) && (!out_valid_q || m_axis_tready_i)) begin
      out_data_q <= {res_q[2], res_q[1], res_q[0]};
    end
  end

  // remainder stays reduced while the shared unit iterates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MOD) || (state_q == ST_FIX) || (state_q == ST_FRAC)) |-> (rem_q < d_q))
    else $error("phase remainder not below period");

  // wave factor is a Q1.8 value no larger than one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLEND) |-> (f_q <= 9'd256))
    else $error("wave factor out of range");

  // the frame counter moves only in the tick update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_TICK_ADD) |=> $stable(frame_q))
    else $error("frame counter changed outside a tick");

  // a new result appears only from the push cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PUSH))
    else $error("result raised outside push cycle");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sine-wave HSV pattern generator. A directed
// table walks reset defaults, wave crest and trough, mirrored and
// off-matrix coordinates, wavelength and speed limits and frame wrap. Random
// phases follow, each with fresh register settings and its own mix of
// sender gaps and receiver stalls. Every color result is checked field by
// field against a fixed table entry or an in-bench predictor that tracks the frame counter.
// ----------------------------------------------------------------------------
module testbench
  import swhsv_pkg::*;
();

  localparam int         HALF_PERIOD    = 6;
  localparam int         RESET_CYCLES   = 7;
  localparam int         SETTLE_CYCLES  = 40;    // longest item (query) plus margin
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         PHASES         = 8;
  localparam int         PHASE_ITEMS    = 116;
  localparam logic [2:0] REG_UNUSED     = 3'd7;  // index past the register list

  // round(128*sin(pi*j/128)), j = 0..64
  localparam int SINE_QUARTER [65] = '{
    0, 3, 6, 9, 13, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
    49, 52, 55, 58, 60, 63, 66, 68, 71, 74, 76, 79, 81, 84, 86, 88,
    91, 93, 95, 97, 99, 101, 103, 105, 106, 108, 110, 111, 113, 114, 116, 117,
    118, 119, 121, 122, 122, 123, 124, 125, 126, 126, 127, 127, 127, 128, 128, 128,
    128
  };

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef enum logic [1:0] {STEP_CFG, STEP_QUERY, STEP_TICK} step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    logic [2:0]  addr;
    logic [15:0] value;
    logic [5:0]  col;
    logic [5:0]  row;
    logic        typed;
    hsv_t        color;
  } step_t;

  localparam int DIR_STEPS = 36;
  localparam step_t DIRECTED [DIR_STEPS] = '{
    // reset defaults: mirrored horizontal wave, frame zero
    '{STEP_QUERY, '0, '0, 6'd31, 6'd0, 1'b1, '{8'd127, 8'd127, 8'd112}},
    '{STEP_QUERY, '0, '0, 6'd63, 6'd63, 1'b0, '0},   // mirrored position negative
    '{STEP_QUERY, '0, '0, 6'd0, 6'd63, 1'b0, '0},
    '{STEP_CFG, REG_REVERSE, 16'h0000, '0, '0, 1'b0, '0},
    '{STEP_CFG, REG_WAVE_LENGTH, 16'h0004, '0, '0, 1'b0, '0},
    '{STEP_QUERY, '0, '0, 6'd1, 6'd0, 1'b1, '{8'd255, 8'd0, 8'd150}},   // crest
    '{STEP_QUERY, '0, '0, 6'd3, 6'd0, 1'b1, '{8'd0, 8'd255, 8'd75}},    // trough
    '{STEP_QUERY, '0, '0, 6'd0, 6'd0, 1'b1, '{8'd127, 8'd127, 8'd112}},
    '{STEP_QUERY, '0, '0, 6'd63, 6'd0, 1'b0, '0},    // beyond the matrix edge
    '{STEP_CFG, REG_WAVE_MODE, 16'h0001, '0, '0, 1'b0, '0},
    '{STEP_QUERY, '0, '0, 6'd0, 6'd1, 1'b1, '{8'd255, 8'd0, 8'd150}},
    '{STEP_QUERY, '0, '0, 6'd63, 6'd3, 1'b1, '{8'd0, 8'd255, 8'd75}},
    '{STEP_CFG, REG_WAVE_LENGTH, 16'h0000, '0, '0, 1'b0, '0},   // saturates to one
    '{STEP_QUERY, '0, '0, 6'd17, 6'd42, 1'b1, '{8'd127, 8'd127, 8'd112}},
    '{STEP_CFG, REG_HUE_BOUNDS, 16'h3737, '0, '0, 1'b0, '0},    // flat hue
    '{STEP_QUERY, '0, '0, 6'd5, 6'd5, 1'b1, '{8'd55, 8'd127, 8'd112}},
    '{STEP_CFG, REG_UNUSED, 16'hFFFF, '0, '0, 1'b0, '0},        // must be ignored
    '{STEP_QUERY, '0, '0, 6'd5, 6'd5, 1'b1, '{8'd55, 8'd127, 8'd112}},
    '{STEP_CFG, REG_WAVE_LENGTH, 16'h00FF, '0, '0, 1'b0, '0},
    '{STEP_CFG, REG_SPEED, 16'h00FF, '0, '0, 1'b0, '0},
    '{STEP_CFG, REG_REVERSE, 16'h0001, '0, '0, 1'b0, '0},
    '{STEP_TICK, '0, '0, 6'd63, 6'd63, 1'b0, '0},
    '{STEP_TICK, '0, '0, 6'd0, 6'd0, 1'b0, '0},
    '{STEP_TICK, '0, '0, 6'd21, 6'd42, 1'b0, '0},
    '{STEP_QUERY, '0, '0, 6'd10, 6'd20, 1'b0, '0},
    '{STEP_CFG, REG_WAVE_LENGTH, 16'h0001, '0, '0, 1'b0, '0},   // frame past period
    '{STEP_QUERY, '0, '0, 6'd40, 6'd9, 1'b0, '0},
    '{STEP_TICK, '0, '0, 6'd0, 6'd0, 1'b0, '0},                 // wraps to one
    '{STEP_QUERY, '0, '0, 6'd2, 6'd2, 1'b0, '0},
    '{STEP_CFG, REG_SPEED, 16'h0000, '0, '0, 1'b0, '0},
    '{STEP_TICK, '0, '0, 6'd7, 6'd7, 1'b0, '0},
    '{STEP_QUERY, '0, '0, 6'd30, 6'd31, 1'b0, '0},
    '{STEP_CFG, REG_WAVE_MODE, 16'h0000, '0, '0, 1'b0, '0},
    '{STEP_CFG, REG_SAT_BOUNDS, 16'h0000, '0, '0, 1'b0, '0},
    '{STEP_CFG, REG_VALUE_BOUNDS, 16'hFFFF, '0, '0, 1'b0, '0},
    '{STEP_QUERY, '0, '0, 6'd63, 6'd63, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;   // [5:0] col, [11:6] row, [15:12] zero
  logic        s_axis_tuser_i  = 1'b0; // [0] func
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;         // [7:0] hue, [15:8] saturation, [23:16] brightness
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i     = '0;
  logic [15:0] cfg_data_i      = '0;

  sine_wave_hsv_pattern uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // predictor copy of the registers and frame counter
  logic               pm_wave_mode = 1'b0;
  logic               pm_reverse   = 1'b1;
  logic [7:0]         pm_length    = RST_WAVE_LENGTH;
  logic [7:0]         pm_speed     = RST_SPEED;
  logic [15:0]        pm_hue       = RST_HUE_BOUNDS;
  logic [15:0]        pm_sat       = RST_SAT_BOUNDS;
  logic [15:0]        pm_value     = RST_VALUE_BOUNDS;
  logic [FRAME_W-1:0] pm_frame     = '0;

  hsv_t expected_colors [$];
  int   errors             = 0;
  int   n_queries          = 0;
  int   n_ticks            = 0;
  int   n_writes           = 0;
  int   n_checked          = 0;
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  bit   need_settle        = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  function automatic logic [7:0] mix_channel(input logic [15:0] bounds, input int f);
    int lo;
    int hi;
    int t;
    lo = int'(bounds[7:0]);
    hi = int'(bounds[15:8]);
    if (lo == hi) return bounds[7:0];
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
      f  = 256 - f;
    end
    t = lo + (((hi - lo) * f) >> 8);
    return t[7:0];
  endfunction

  function automatic hsv_t pixel_color(input logic [5:0] col, input logic [5:0] row);
    int     pos;
    int     idx;
    int     j;
    int     mag;
    int     f;
    longint unit_len;
    longint period;
    longint rem;
    hsv_t   c;
    if (pm_wave_mode == 1'b0) pos = pm_reverse ? MATRIX_WIDTH - 1 - int'(col) : int'(col);
    else pos = pm_reverse ? MATRIX_HEIGHT - 1 - int'(row) : int'(row);
    unit_len = longint'(FRAMES_PER_SECOND * 10);
    period   = unit_len * longint'(pm_length);
    rem      = (longint'(pos) * unit_len - longint'(pm_frame)) % period;
    if (rem < 0) rem += period;
    idx = int'((rem * 256) / period) & 255;
    j   = idx & 63;
    mag = ((idx >> 6) & 1) ? SINE_QUARTER[64 - j] : SINE_QUARTER[j];
    f   = ((idx >> 7) & 1) ? 128 - mag : 128 + mag;
    c.hue        = mix_channel(pm_hue, f);
    c.saturation = mix_channel(pm_sat, f);
    c.brightness = mix_channel(pm_value, f);
    return c;
  endfunction

  task automatic send_item(input logic func, input logic [5:0] col, input logic [5:0] row,
                           input bit typed, input hsv_t fixed);
    int limit;
    int next_frame;
    cfg_valid_i <= 1'b0;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= {4'b0000, row, col};
    do @(posedge clk_i); while (!s_axis_tready_o);
    need_settle = 1'b1;
    if (func == FUNC_TICK) begin
      limit      = int'(pm_length) * FRAMES_PER_SECOND * 10;
      next_frame = int'(pm_frame) + (int'(pm_length) * int'(pm_speed)) / 10;
      if (next_frame >= limit) next_frame = 1;
      pm_frame = next_frame[FRAME_W-1:0];
      n_ticks++;
    end else begin
      expected_colors.push_back(typed ? fixed : pixel_color(col, row));
      n_queries++;
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= addr;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_writes++;
    case (addr)
      REG_WAVE_MODE:    pm_wave_mode = value[0];
      REG_REVERSE:      pm_reverse   = value[0];
      REG_WAVE_LENGTH:  pm_length    = (value[7:0] == 8'd0) ? 8'd1 : value[7:0];
      REG_SPEED:        pm_speed     = value[7:0];
      REG_HUE_BOUNDS:   pm_hue       = value;
      REG_SAT_BOUNDS:   pm_sat       = value;
      REG_VALUE_BOUNDS: pm_value     = value;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_colors.size() != 0);
  endtask

  // a tick yields no result, so let the block finish before touching registers
  task automatic wait_idle();
    if (need_settle) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      need_settle = 1'b0;
    end
  endtask

  function automatic logic [15:0] pick_bounds();
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(5))
      0: return {b, b};
      1: return 16'h0000;
      2: return 16'hFFFF;
      3: return 16'h00FF;
      4: return 16'hFF00;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin : check_output
    hsv_t got;
    hsv_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.hue        = m_axis_tdata_o[7:0];
      got.saturation = m_axis_tdata_o[15:8];
      got.brightness = m_axis_tdata_o[23:16];
      if (expected_colors.size() == 0) begin
        $error("color transfer with no pending query: tdata %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        n_checked++;
        if (got.hue != want.hue) begin
          $error("hue: expected %0d, actual %0d", want.hue, got.hue);
          errors++;
        end
        if (got.saturation != want.saturation) begin
          $error("saturation: expected %0d, actual %0d", want.saturation, got.saturation);
          errors++;
        end
        if (got.brightness != want.brightness) begin
          $error("brightness: expected %0d, actual %0d", want.brightness, got.brightness);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    step_t      st;
    logic [7:0] byte_hi;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_STEPS; i++) begin
      st = DIRECTED[i];
      if (st.kind == STEP_CFG) begin
        wait_idle();
        write_reg(st.addr, st.value);
      end else begin
        send_item(st.kind == STEP_TICK ? FUNC_TICK : FUNC_QUERY, st.col, st.row,
                  st.typed, st.color);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
        default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
      endcase
      // upper data bits are random so that masking of narrow registers is exercised
      write_reg(REG_WAVE_MODE, 16'($urandom));
      write_reg(REG_REVERSE, 16'($urandom));
      byte_hi = 8'($urandom);
      case ($urandom_range(2))
        0: write_reg(REG_WAVE_LENGTH, {byte_hi, 8'h00});
        1: write_reg(REG_WAVE_LENGTH, {byte_hi, 8'hFF});
        default: write_reg(REG_WAVE_LENGTH, 16'($urandom));
      endcase
      case ($urandom_range(2))
        0: write_reg(REG_SPEED, {byte_hi, 8'h00});
        1: write_reg(REG_SPEED, {byte_hi, 8'hFF});
        default: write_reg(REG_SPEED, 16'($urandom));
      endcase
      write_reg(REG_HUE_BOUNDS, pick_bounds());
      write_reg(REG_SAT_BOUNDS, pick_bounds());
      write_reg(REG_VALUE_BOUNDS, pick_bounds());
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 16'($urandom));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        send_item(($urandom_range(5) == 0) ? FUNC_TICK : FUNC_QUERY,
                  6'($urandom_range(63)), 6'($urandom_range(63)), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("checked %0d color results from %0d queries and %0d frame ticks",
             n_checked, n_queries, n_ticks);
    $display("%0d register writes over %0d random settings, gaps and stalls of 0/56/6 pct",
             n_writes, PHASES);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
